// File: rtl/core/pdwd_pkg.sv
// Shared types and constants for the wall-distance PD motor drive.
package pdwd_pkg;

   localparam int DIST_W    = 12;
   localparam int GAIN_W    = 16;
   localparam int LIMIT_W   = 10;
   localparam int FLOOR_W   = 8;
   localparam int ERR_W     = 13;
   localparam int DIFF_W    = 14;
   localparam int CTRL_W    = 11;
   localparam int PWM_W     = 9;
   localparam int DUTY_W    = 8;
   localparam int ACC_W     = 32;
   localparam int SCALE_SH  = 8;
   localparam int PWM_CLAMP = 255;

   // shared multiplier operand widths (signed)
   localparam int MUL_A_W   = GAIN_W + 1;
   localparam int MUL_B_W   = DIFF_W;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_FWD   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_REV   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_FWD  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_REV  = 3'd7;

   localparam logic [DIST_W-1:0]  RST_SETPOINT   = 12'd0;
   localparam logic [GAIN_W-1:0]  RST_GAIN_P     = 16'd384;
   localparam logic [GAIN_W-1:0]  RST_GAIN_D     = 16'd1024;
   localparam logic [LIMIT_W-1:0] RST_CTRL_LIMIT = 10'd500;
   localparam logic [FLOOR_W-1:0] RST_LEFT_FWD   = 8'd55;
   localparam logic [FLOOR_W-1:0] RST_LEFT_REV   = 8'd30;
   localparam logic [FLOOR_W-1:0] RST_RIGHT_FWD  = 8'd28;
   localparam logic [FLOOR_W-1:0] RST_RIGHT_REV  = 8'd28;

   localparam logic OP_STEP = 1'b0;
   localparam logic OP_STOP = 1'b1;

   localparam logic WHEEL_LEFT  = 1'b0;
   localparam logic WHEEL_RIGHT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_D,
      ST_SCALE,
      ST_MAP_MUL,
      ST_MAP_ABS,
      ST_DIV,
      ST_MAP_FIN,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/core/pdwd_req_if.sv
// Sample channel: op and distance with valid/ready.
interface pdwd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [pdwd_pkg::DIST_W-1:0]   distance;

   modport source (output valid, output op, output distance, input ready);
   modport sink   (input valid, input op, input distance, output ready);
endinterface

// File: rtl/core/pdwd_rsp_if.sv
// Drive result channel: control value, wheel PWMs and pin duties with valid/ready.
interface pdwd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pdwd_pkg::CTRL_W-1:0]  control_value;
   logic signed [pdwd_pkg::PWM_W-1:0]   left_drive;
   logic signed [pdwd_pkg::PWM_W-1:0]   right_drive;
   logic [pdwd_pkg::DUTY_W-1:0]         left_fwd_duty;
   logic [pdwd_pkg::DUTY_W-1:0]         left_rev_duty;
   logic [pdwd_pkg::DUTY_W-1:0]         right_fwd_duty;
   logic [pdwd_pkg::DUTY_W-1:0]         right_rev_duty;

   modport source (output valid, output control_value, output left_drive, output right_drive,
                   output left_fwd_duty, output left_rev_duty, output right_fwd_duty,
                   output right_rev_duty, input ready);
   modport sink   (input valid, input control_value, input left_drive, input right_drive,
                   input left_fwd_duty, input left_rev_duty, input right_fwd_duty,
                   input right_rev_duty, output ready);
endinterface

// File: rtl/core/pd_wall_distance_motor_drive.sv
// PD wall-distance controller with dead-band-compensated two-wheel PWM drive.
//
// Usage: each transfer on req_chan carries an op and a distance sample. A step op
// forms error = distance - setpoint, computes the Q8.8 PD sum, truncates it toward
// zero, clamps it to +/- min(ctrl_limit, MAP_SPAN) and maps it onto a signed PWM and
// a pair of pin duties per wheel. A stop op returns all zeros and keeps the stored
// error. Each transfer yields exactly one transfer on rsp_chan.
// Datapath: one shared multiplier is stepped by a sequencer. It forms both PD products,
// the map product of each wheel and, as a multiply by a fixed reciprocal, the divide
// by MAP_SPAN. A step op runs the PD sum and clamp (MUL_P, MUL_D, SCALE), then per
// wheel the product, magnitude, reciprocal multiply, and offset and saturation
// (MAP_MUL, MAP_ABS, DIV, MAP_FIN), then loads the output register (FINISH). A stop op
// goes straight to FINISH. req_chan.ready is high only while no sample is in work, so a
// new sample is accepted only once the last one has been loaded into the output register.
// rsp_chan is driven from an output register: a finished result may wait there
// while the next sample is accepted; a stalled receiver holds the block only when
// the next result is ready to be written.
// Reset (synchronous, active high) loads the register defaults, clears the stored
// error and empties the output register. csr_* writes take effect at the next edge,
// so they belong between samples while the block is idle.
module pd_wall_distance_motor_drive #(
   parameter int MAP_SPAN = 1000,
   parameter int PWM_FULL = 255
) (
   input  logic                               clock,
   input  logic                               reset,
   pdwd_req_if.sink                           req_chan,
   pdwd_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [pdwd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pdwd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SPAN_W  = $clog2(MAP_SPAN + 1);
   localparam int FMAG    = (PWM_FULL > pdwd_pkg::PWM_CLAMP) ? PWM_FULL : pdwd_pkg::PWM_CLAMP;
   localparam int FMAG_W  = $clog2(FMAG + 1);
   localparam int FAC_W   = FMAG_W + 1;
   localparam int PROD_W  = SPAN_W + FMAG_W;
   localparam int Q_W     = PROD_W + 1;
   localparam int PW_W    = Q_W + 1;
   localparam int ACC_W   = pdwd_pkg::ACC_W;
   localparam int CTRL_W  = pdwd_pkg::CTRL_W;
   localparam int ERR_W   = pdwd_pkg::ERR_W;
   localparam int DIFF_W  = pdwd_pkg::DIFF_W;
   localparam int PWM_W   = pdwd_pkg::PWM_W;
   localparam int DUTY_W  = pdwd_pkg::DUTY_W;
   localparam int FLOOR_W = pdwd_pkg::FLOOR_W;
   localparam int LIMIT_W = pdwd_pkg::LIMIT_W;
   // x / MAP_SPAN == (x * RECIP_M) >> RECIP_SH for every x below 2**PROD_W
   localparam int RECIP_SH = PROD_W + SPAN_W;
   localparam int M_W      = PROD_W + 2;
   localparam longint unsigned RECIP_L =
      ((64'd1 << RECIP_SH) + 64'(MAP_SPAN) - 64'd1) / 64'(MAP_SPAN);
   localparam logic [M_W-1:0] RECIP_M = M_W'(RECIP_L);
   localparam int MUL_A_W = (pdwd_pkg::MUL_A_W > PROD_W + 1) ? pdwd_pkg::MUL_A_W : PROD_W + 1;
   localparam int MUL_B_W = (pdwd_pkg::MUL_B_W > M_W + 1) ? pdwd_pkg::MUL_B_W : M_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // config registers
   logic [pdwd_pkg::DIST_W-1:0]  setpoint_ff;
   logic [pdwd_pkg::GAIN_W-1:0]  gain_p_ff;
   logic [pdwd_pkg::GAIN_W-1:0]  gain_d_ff;
   logic [LIMIT_W-1:0]           ctrl_limit_ff;
   logic [FLOOR_W-1:0]           left_fwd_ff;
   logic [FLOOR_W-1:0]           left_rev_ff;
   logic [FLOOR_W-1:0]           right_fwd_ff;
   logic [FLOOR_W-1:0]           right_rev_ff;

   // control state
   pdwd_pkg::state_type          state_ff, state_in;
   logic signed [ERR_W-1:0]      last_err_ff, last_err_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // datapath
   logic                         stop_ff, stop_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic signed [DIFF_W-1:0]     diff_ff, diff_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [CTRL_W-1:0]     ctrl_ff, ctrl_in;
   logic                         wheel_ff, wheel_in;
   logic                         neg_ff, neg_in;
   logic [PROD_W-1:0]            quo_ff, quo_in;
   logic signed [PWM_W-1:0]      lpwm_ff, lpwm_in;
   logic signed [PWM_W-1:0]      rpwm_ff, rpwm_in;

   // output register
   logic signed [CTRL_W-1:0]     rsp_ctrl_ff, rsp_ctrl_in;
   logic signed [PWM_W-1:0]      rsp_lpwm_ff, rsp_lpwm_in;
   logic signed [PWM_W-1:0]      rsp_rpwm_ff, rsp_rpwm_in;
   logic [DUTY_W-1:0]            rsp_lfwd_ff, rsp_lfwd_in;
   logic [DUTY_W-1:0]            rsp_lrev_ff, rsp_lrev_in;
   logic [DUTY_W-1:0]            rsp_rfwd_ff, rsp_rfwd_in;
   logic [DUTY_W-1:0]            rsp_rrev_ff, rsp_rrev_in;

   // combinational helpers
   logic                         req_xfer;
   logic                         rsp_load;
   logic                         ctrl_pos;
   logic [FLOOR_W-1:0]           fwd_sel;
   logic [FLOOR_W-1:0]           rev_sel;
   logic [FLOOR_W-1:0]           floor_sel;
   logic signed [DIFF_W-1:0]     ctrl_wide;
   logic [SPAN_W-1:0]            map_opnd;
   logic signed [FAC_W-1:0]      map_fac;
   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic signed [MUL_P_W-1:0]    mul_p;
   logic signed [ACC_W-1:0]      mul_ext;
   logic signed [ACC_W-1:0]      acc_mag;
   logic signed [ACC_W-1:0]      biased;
   logic signed [ACC_W-1:0]      scaled;
   logic signed [ACC_W-1:0]      lim_pos;
   logic [LIMIT_W-1:0]           lim;
   logic signed [Q_W-1:0]        q_signed;
   logic signed [PW_W-1:0]       pwm_raw;
   logic signed [PWM_W-1:0]      pwm_sat;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == pdwd_pkg::ST_IDLE);

   // wheel and sign dependent mapping operands
   assign ctrl_pos  = !ctrl_ff[CTRL_W-1];
   assign fwd_sel   = (wheel_ff == pdwd_pkg::WHEEL_RIGHT) ? right_fwd_ff : left_fwd_ff;
   assign rev_sel   = (wheel_ff == pdwd_pkg::WHEEL_RIGHT) ? right_rev_ff : left_rev_ff;
   assign floor_sel = ctrl_pos ? fwd_sel : rev_sel;
   assign ctrl_wide = {{(DIFF_W-CTRL_W){ctrl_ff[CTRL_W-1]}}, ctrl_ff};
   // control magnitude is bounded by MAP_SPAN, so the truncation is lossless
   assign map_opnd  = ctrl_pos ? SPAN_W'(ctrl_wide)
                               : SPAN_W'(ctrl_wide + DIFF_W'(MAP_SPAN));
   assign map_fac   = $signed(FAC_W'(PWM_FULL))
                      - $signed({{(FAC_W-FLOOR_W){1'b0}}, floor_sel});

   // shared multiplier
   always_comb begin
      unique case (state_ff)
         pdwd_pkg::ST_MUL_P: begin
            mul_a = $signed(MUL_A_W'(gain_p_ff));
            mul_b = MUL_B_W'(err_ff);
         end
         pdwd_pkg::ST_MUL_D: begin
            mul_a = $signed(MUL_A_W'(gain_d_ff));
            mul_b = MUL_B_W'(diff_ff);
         end
         pdwd_pkg::ST_DIV: begin
            mul_a = $signed(MUL_A_W'(quo_ff));
            mul_b = $signed(MUL_B_W'(RECIP_M));
         end
         default: begin
            mul_a = $signed(MUL_A_W'(map_opnd));
            mul_b = MUL_B_W'(map_fac);
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   // PD and map products fit the accumulator
   assign mul_ext = ACC_W'(mul_p);

   // divide by 256, truncating toward zero
   assign biased  = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
   assign scaled  = biased >>> pdwd_pkg::SCALE_SH;
   assign lim     = (ctrl_limit_ff > LIMIT_W'(MAP_SPAN) && MAP_SPAN < 1024)
                    ? LIMIT_W'(MAP_SPAN) : ctrl_limit_ff;
   assign lim_pos = $signed({{(ACC_W-LIMIT_W){1'b0}}, lim});

   assign acc_mag = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;

   assign q_signed = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   always_comb begin
      if (ctrl_pos) begin
         pwm_raw = PW_W'(q_signed) + $signed({{(PW_W-FLOOR_W){1'b0}}, floor_sel});
      end else begin
         pwm_raw = PW_W'(q_signed) - $signed(PW_W'(PWM_FULL));
      end
      priority if (pwm_raw > $signed(PW_W'(pdwd_pkg::PWM_CLAMP))) begin
         pwm_sat = PWM_W'(pdwd_pkg::PWM_CLAMP);
      end else if (pwm_raw < -$signed(PW_W'(pdwd_pkg::PWM_CLAMP))) begin
         pwm_sat = -$signed(PWM_W'(pdwd_pkg::PWM_CLAMP));
      end else begin
         pwm_sat = PWM_W'(pwm_raw);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      last_err_in  = last_err_ff;
      stop_in      = stop_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      ctrl_in      = ctrl_ff;
      wheel_in     = wheel_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      lpwm_in      = lpwm_ff;
      rpwm_in      = rpwm_ff;
      rsp_load     = 1'b0;

      unique case (state_ff)
         pdwd_pkg::ST_IDLE: begin
            if (req_xfer) begin
               stop_in = (req_chan.op == pdwd_pkg::OP_STOP);
               err_in  = $signed({1'b0, req_chan.distance}) - $signed({1'b0, setpoint_ff});
               state_in = (req_chan.op == pdwd_pkg::OP_STOP) ? pdwd_pkg::ST_FINISH
                                                             : pdwd_pkg::ST_MUL_P;
            end
         end
         pdwd_pkg::ST_MUL_P: begin
            acc_in   = mul_ext;
            diff_in  = $signed({err_ff[ERR_W-1], err_ff})
                       - $signed({last_err_ff[ERR_W-1], last_err_ff});
            state_in = pdwd_pkg::ST_MUL_D;
         end
         pdwd_pkg::ST_MUL_D: begin
            acc_in   = acc_ff + mul_ext;
            state_in = pdwd_pkg::ST_SCALE;
         end
         pdwd_pkg::ST_SCALE: begin
            priority if (scaled >= lim_pos) begin
               ctrl_in = CTRL_W'(lim_pos);
            end else if (scaled <= -lim_pos) begin
               ctrl_in = CTRL_W'(-lim_pos);
            end else begin
               ctrl_in = CTRL_W'(scaled);
            end
            last_err_in = err_ff;
            wheel_in    = pdwd_pkg::WHEEL_LEFT;
            state_in    = pdwd_pkg::ST_MAP_MUL;
         end
         pdwd_pkg::ST_MAP_MUL: begin
            acc_in   = mul_ext;
            state_in = pdwd_pkg::ST_MAP_ABS;
         end
         pdwd_pkg::ST_MAP_ABS: begin
            neg_in   = acc_ff[ACC_W-1];
            quo_in   = PROD_W'(acc_mag);
            state_in = pdwd_pkg::ST_DIV;
         end
         pdwd_pkg::ST_DIV: begin
            // magnitude / MAP_SPAN by reciprocal multiply, exact over the product range
            quo_in   = PROD_W'(mul_p >>> RECIP_SH);
            state_in = pdwd_pkg::ST_MAP_FIN;
         end
         pdwd_pkg::ST_MAP_FIN: begin
            if (wheel_ff == pdwd_pkg::WHEEL_RIGHT) begin
               rpwm_in  = pwm_sat;
               state_in = pdwd_pkg::ST_FINISH;
            end else begin
               lpwm_in  = pwm_sat;
               wheel_in = pdwd_pkg::WHEEL_RIGHT;
               state_in = pdwd_pkg::ST_MAP_MUL;
            end
         end
         pdwd_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = pdwd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdwd_pkg::ST_IDLE;
         end
      endcase
   end

   // output register contents
   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
      rsp_ctrl_in  = rsp_ctrl_ff;
      rsp_lpwm_in  = rsp_lpwm_ff;
      rsp_rpwm_in  = rsp_rpwm_ff;
      rsp_lfwd_in  = rsp_lfwd_ff;
      rsp_lrev_in  = rsp_lrev_ff;
      rsp_rfwd_in  = rsp_rfwd_ff;
      rsp_rrev_in  = rsp_rrev_ff;
      if (rsp_load) begin
         if (stop_ff) begin
            rsp_ctrl_in = '0;
            rsp_lpwm_in = '0;
            rsp_rpwm_in = '0;
            rsp_lfwd_in = '0;
            rsp_lrev_in = '0;
            rsp_rfwd_in = '0;
            rsp_rrev_in = '0;
         end else begin
            rsp_ctrl_in = ctrl_ff;
            rsp_lpwm_in = lpwm_ff;
            rsp_rpwm_in = rpwm_ff;
            rsp_lfwd_in = lpwm_ff[PWM_W-1] ? '0 : DUTY_W'(lpwm_ff);
            rsp_lrev_in = lpwm_ff[PWM_W-1] ? DUTY_W'(-lpwm_ff) : '0;
            rsp_rfwd_in = rpwm_ff[PWM_W-1] ? '0 : DUTY_W'(rpwm_ff);
            rsp_rrev_in = rpwm_ff[PWM_W-1] ? DUTY_W'(-rpwm_ff) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pdwd_pkg::ST_IDLE;
         last_err_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         setpoint_ff   <= pdwd_pkg::RST_SETPOINT;
         gain_p_ff     <= pdwd_pkg::RST_GAIN_P;
         gain_d_ff     <= pdwd_pkg::RST_GAIN_D;
         ctrl_limit_ff <= pdwd_pkg::RST_CTRL_LIMIT;
         left_fwd_ff   <= pdwd_pkg::RST_LEFT_FWD;
         left_rev_ff   <= pdwd_pkg::RST_LEFT_REV;
         right_fwd_ff  <= pdwd_pkg::RST_RIGHT_FWD;
         right_rev_ff  <= pdwd_pkg::RST_RIGHT_REV;
      end else begin
         state_ff     <= state_in;
         last_err_ff  <= last_err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               pdwd_pkg::REG_SETPOINT:   setpoint_ff   <= csr_wdata[pdwd_pkg::DIST_W-1:0];
               pdwd_pkg::REG_GAIN_P:     gain_p_ff     <= csr_wdata[pdwd_pkg::GAIN_W-1:0];
               pdwd_pkg::REG_GAIN_D:     gain_d_ff     <= csr_wdata[pdwd_pkg::GAIN_W-1:0];
               pdwd_pkg::REG_CTRL_LIMIT: ctrl_limit_ff <= csr_wdata[LIMIT_W-1:0];
               pdwd_pkg::REG_LEFT_FWD:   left_fwd_ff   <= csr_wdata[FLOOR_W-1:0];
               pdwd_pkg::REG_LEFT_REV:   left_rev_ff   <= csr_wdata[FLOOR_W-1:0];
               pdwd_pkg::REG_RIGHT_FWD:  right_fwd_ff  <= csr_wdata[FLOOR_W-1:0];
               pdwd_pkg::REG_RIGHT_REV:  right_rev_ff  <= csr_wdata[FLOOR_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      stop_ff     <= stop_in;
      err_ff      <= err_in;
      diff_ff     <= diff_in;
      acc_ff      <= acc_in;
      ctrl_ff     <= ctrl_in;
      wheel_ff    <= wheel_in;
      neg_ff      <= neg_in;
      quo_ff      <= quo_in;
      lpwm_ff     <= lpwm_in;
      rpwm_ff     <= rpwm_in;
      rsp_ctrl_ff <= rsp_ctrl_in;
      rsp_lpwm_ff <= rsp_lpwm_in;
      rsp_rpwm_ff <= rsp_rpwm_in;
      rsp_lfwd_ff <= rsp_lfwd_in;
      rsp_lrev_ff <= rsp_lrev_in;
      rsp_rfwd_ff <= rsp_rfwd_in;
      rsp_rrev_ff <= rsp_rrev_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.control_value  = rsp_ctrl_ff;
   assign rsp_chan.left_drive     = rsp_lpwm_ff;
   assign rsp_chan.right_drive    = rsp_rpwm_ff;
   assign rsp_chan.left_fwd_duty  = rsp_lfwd_ff;
   assign rsp_chan.left_rev_duty  = rsp_lrev_ff;
   assign rsp_chan.right_fwd_duty = rsp_rfwd_ff;
   assign rsp_chan.right_rev_duty = rsp_rrev_ff;

   // a sample in work blocks further transfers
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_chan.ready)
      else $error("sample accepted while another is in work");

   // map quotient never exceeds the full-scale factor
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdwd_pkg::ST_MAP_FIN) |-> (quo_ff <= PROD_W'(FMAG)))
      else $error("map quotient out of range");

   // only one pin per wheel is driven
   a_duty_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_lfwd_ff == '0 || rsp_lrev_ff == '0)
                        && (rsp_rfwd_ff == '0 || rsp_rrev_ff == '0)))
      else $error("forward and reverse duty both nonzero");

   // saturated PWM never reaches the most negative code
   a_pwm_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_lpwm_ff != {1'b1, {(PWM_W-1){1'b0}}}
                        && rsp_rpwm_ff != {1'b1, {(PWM_W-1){1'b0}}}))
      else $error("PWM outside saturation range");

endmodule
